@@ rtl/bft_pkg.sv @@
// ----------------------------------------------------------------------------
// bft_pkg : shared codes and widths for the bidirectional flow table
// Status codes, protocol numbers and counter widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bft_pkg;
   localparam logic [1:0] STATUS_UPDATED = 2'd0;
   localparam logic [1:0] STATUS_CREATED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [7:0] PROTO_TCP      = 8'd6;
   localparam logic [7:0] PROTO_UDP      = 8'd17;
   localparam int PKT_W  = 32;
   localparam int BYTE_W = 48;
endpackage
`default_nettype wire

@@ rtl/bidirectional_flow_table_core.sv @@
// ----------------------------------------------------------------------------
// bidirectional_flow_table_core : 5-tuple flow table with per-direction counts
// Sequential search over a key memory, then one read-modify-write of the entry.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The key memory is read
// one entry a cycle; each entry read is compared against the key both as sent
// and swapped, so the search covers all TABLE_DEPTH entries. Then ST_READ
// picks the entry, ST_WAIT reads its record and ST_WRITE updates it, writes
// it back and registers the result. The result sits on the rsp_ ports in the
// next cycle, when busy is already low again. Busy is high for a TCP or UDP
// item until ST_WRITE, so the next item can be taken at the same edge as the
// result. Other protocols are taken without leaving idle and give no result.
// The result is on the rsp_ ports for exactly one cycle, marked by rsp_valid;
// the receiver cannot stall.
// The first match in the stored orientation wins over any reversed match;
// a miss takes the lowest free entry, found during the same pass.
`timescale 1ns / 1ps
`default_nettype none
module bidirectional_flow_table_core
   import bft_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_src_address,
   input  wire logic [31:0] req_dst_address,
   input  wire logic [7:0]  req_ip_protocol,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [15:0] req_packet_length,
   input  wire logic [31:0] req_ts_seconds,
   input  wire logic [19:0] req_ts_micros,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_direction,
   output logic [31:0]      rsp_stream_number,
   output logic [31:0]      rsp_total_packets,
   output logic [47:0]      rsp_total_bytes,
   output logic [31:0]      rsp_fwd_packets,
   output logic [47:0]      rsp_fwd_bytes,
   output logic [31:0]      rsp_rev_packets,
   output logic [47:0]      rsp_rev_bytes,
   output logic [31:0]      rsp_start_seconds,
   output logic [19:0]      rsp_start_micros
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 97;
   localparam int REC_W = 32 + 3 * PKT_W + 3 * BYTE_W + 52;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_READ, ST_WAIT, ST_WRITE
   } state_type;

   // key: is_udp, src addr, dst addr, src port, dst port
   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [REC_W-1:0] rec_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   state_type        state_ff;
   logic [CNT_W-1:0] rd_cnt_ff;       // next address to issue
   logic [IDX_W-1:0] cmp_idx_ff;      // index of the entry in key_rd_ff
   logic             cmp_vld_ff;
   logic [KEY_W-1:0] key_rd_ff;
   logic [REC_W-1:0] rec_rd_ff;
   logic [KEY_W-1:0] key_ff, rkey_ff;
   logic [15:0]      len_ff;
   logic [51:0]      ts_ff;
   logic             fhit_ff, rhit_ff, free_ff;
   logic [IDX_W-1:0] fidx_ff, ridx_ff, free_idx_ff, sel_ff;
   logic [31:0]      tcp_next_ff, udp_next_ff;
   logic [REC_W-1:0] wr_rec;

   wire logic is_tcp = (req_ip_protocol == PROTO_TCP);
   wire logic is_udp = (req_ip_protocol == PROTO_UDP);
   wire logic take   = start && !busy;
   wire logic cmp_fwd = cmp_vld_ff && valid_ff[cmp_idx_ff] && key_rd_ff == key_ff;
   wire logic cmp_rev = cmp_vld_ff && valid_ff[cmp_idx_ff] && key_rd_ff == rkey_ff;

   assign busy = (state_ff != ST_IDLE);

   // memory ports: key read one address a cycle, record read, write-back
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[rd_cnt_ff[IDX_W-1:0]];
      rec_rd_ff <= rec_mem[sel_ff];
      if (state_ff == ST_WRITE && !fhit_ff && !rhit_ff && free_ff) begin
         key_mem[free_idx_ff] <= key_ff;
      end
      if (state_ff == ST_WRITE && (fhit_ff || rhit_ff || free_ff)) begin
         rec_mem[sel_ff] <= wr_rec;
      end
   end

   // counter update from the record read, or a new record on a miss
   always_comb begin
      logic [31:0] sn, tp, fp, rp;
      logic [47:0] tb, fb, rb;
      logic [51:0] st;
      logic [48:0] s;
      s = '0;
      {sn, tp, tb, fp, fb, rp, rb, st} = rec_rd_ff;
      if (fhit_ff || rhit_ff) begin
         tp = (tp == '1) ? tp : tp + 32'd1;
         s  = {1'b0, tb} + {33'd0, len_ff};
         tb = s[48] ? '1 : s[47:0];
         if (fhit_ff) begin
            fp = (fp == '1) ? fp : fp + 32'd1;
            s  = {1'b0, fb} + {33'd0, len_ff};
            fb = s[48] ? '1 : s[47:0];
         end else begin
            rp = (rp == '1) ? rp : rp + 32'd1;
            s  = {1'b0, rb} + {33'd0, len_ff};
            rb = s[48] ? '1 : s[47:0];
         end
      end else begin
         sn = key_ff[KEY_W-1] ? udp_next_ff : tcp_next_ff;
         tp = 32'd1;
         tb = {32'd0, len_ff};
         fp = 32'd1;
         fb = {32'd0, len_ff};
         rp = '0;
         rb = '0;
         st = ts_ff;
      end
      wr_rec = {sn, tp, tb, fp, fb, rp, rb, st};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         tcp_next_ff <= '0;
         udp_next_ff <= '0;
         rsp_valid   <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         rd_cnt_ff   <= '0;
      end else begin
         rsp_valid <= (state_ff == ST_WRITE);
         case (state_ff)
            ST_IDLE: begin
               if (take && (is_tcp || is_udp)) begin
                  key_ff  <= {is_udp, req_src_address, req_dst_address,
                              req_src_port, req_dst_port};
                  rkey_ff <= {is_udp, req_dst_address, req_src_address,
                              req_dst_port, req_src_port};
                  len_ff  <= req_packet_length;
                  ts_ff   <= {req_ts_seconds, req_ts_micros};
                  fhit_ff <= 1'b0;
                  rhit_ff <= 1'b0;
                  free_ff <= 1'b0;
                  rd_cnt_ff <= CNT_W'(1);
                  cmp_idx_ff <= '0;
                  cmp_vld_ff <= 1'b1;
                  state_ff  <= ST_SEARCH;
               end else begin
                  cmp_vld_ff <= 1'b0;
                  rd_cnt_ff  <= '0;
               end
            end
            ST_SEARCH: begin
               // compare the entry read last cycle, issue the next address
               if (cmp_fwd && !fhit_ff) begin
                  fhit_ff <= 1'b1;
                  fidx_ff <= cmp_idx_ff;
               end
               if (cmp_rev && !rhit_ff) begin
                  rhit_ff <= 1'b1;
                  ridx_ff <= cmp_idx_ff;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
               if (rd_cnt_ff == DEPTH_C) begin
                  cmp_vld_ff <= 1'b0;
                  rd_cnt_ff  <= '0;
                  state_ff   <= ST_READ;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
               end
            end
            ST_READ: begin
               sel_ff   <= fhit_ff ? fidx_ff : (rhit_ff ? ridx_ff : free_idx_ff);
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               state_ff  <= ST_IDLE;
               if (fhit_ff || rhit_ff) begin
                  rsp_status    <= STATUS_UPDATED;
                  rsp_direction <= !fhit_ff;
                  {rsp_stream_number, rsp_total_packets, rsp_total_bytes,
                   rsp_fwd_packets, rsp_fwd_bytes, rsp_rev_packets, rsp_rev_bytes,
                   rsp_start_seconds, rsp_start_micros} <= wr_rec;
               end else if (free_ff) begin
                  rsp_status    <= STATUS_CREATED;
                  rsp_direction <= 1'b0;
                  {rsp_stream_number, rsp_total_packets, rsp_total_bytes,
                   rsp_fwd_packets, rsp_fwd_bytes, rsp_rev_packets, rsp_rev_bytes,
                   rsp_start_seconds, rsp_start_micros} <= wr_rec;
                  valid_ff[free_idx_ff] <= 1'b1;
                  if (key_ff[KEY_W-1]) udp_next_ff <= udp_next_ff + 32'd1;
                  else                 tcp_next_ff <= tcp_next_ff + 32'd1;
               end else begin
                  rsp_status    <= STATUS_FULL;
                  rsp_direction <= 1'b0;
                  {rsp_stream_number, rsp_total_packets, rsp_total_bytes,
                   rsp_fwd_packets, rsp_fwd_bytes, rsp_rev_packets, rsp_rev_bytes,
                   rsp_start_seconds, rsp_start_micros} <= '0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_WRITE) else $error("stray result");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> !rsp_valid) else $error("result mid search");
   a_one_new: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) >= $countones($past(valid_ff))) else $error("entry lost");
endmodule
`default_nettype wire

@@ dv/bidirectional_flow_table_core_test.sv @@
// ----------------------------------------------------------------------------
// bidirectional_flow_table_core_test : self-checking bench for the flow table
// Drives parsed packet headers, mirrors the table in a local model and checks
// every response field by field, in order, against the mirrored expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bidirectional_flow_table_core_test;
   import bft_pkg::*;

   localparam int DEPTH       = 64;
   localparam int NUM_RANDOM  = 1600;
   localparam int QUIET_TAIL  = 150;  // last items are sent back to back
   localparam int SETTLE      = 80;   // a little over one search pass

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
   } flow_key_type;

   typedef struct {
      flow_key_type key;
      logic [15:0]  length;
      logic [31:0]  secs;
      logic [19:0]  usecs;
      bit           drain_first;   // hold off until all responses are in
   } packet_type;

   typedef struct {
      logic [1:0]  status;
      logic        direction;
      logic [31:0] stream;
      logic [31:0] tot_pkts;
      logic [47:0] tot_bytes;
      logic [31:0] fwd_pkts;
      logic [47:0] fwd_bytes;
      logic [31:0] rev_pkts;
      logic [47:0] rev_bytes;
      logic [31:0] start_secs;
      logic [19:0] start_usecs;
   } flow_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_src_address   = '0;
   logic [31:0] req_dst_address   = '0;
   logic [7:0]  req_ip_protocol   = '0;
   logic [15:0] req_src_port      = '0;
   logic [15:0] req_dst_port      = '0;
   logic [15:0] req_packet_length = '0;
   logic [31:0] req_ts_seconds    = '0;
   logic [19:0] req_ts_micros     = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_direction;
   logic [31:0] rsp_stream_number;
   logic [31:0] rsp_total_packets;
   logic [47:0] rsp_total_bytes;
   logic [31:0] rsp_fwd_packets;
   logic [47:0] rsp_fwd_bytes;
   logic [31:0] rsp_rev_packets;
   logic [47:0] rsp_rev_bytes;
   logic [31:0] rsp_start_seconds;
   logic [19:0] rsp_start_micros;

   bidirectional_flow_table_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---- mirrored flow table ----
   bit           flow_used   [DEPTH];
   flow_key_type flow_key    [DEPTH];
   logic [31:0]  flow_stream [DEPTH];
   logic [31:0]  flow_tpkts  [DEPTH];
   logic [47:0]  flow_tbytes [DEPTH];
   logic [31:0]  flow_fpkts  [DEPTH];
   logic [47:0]  flow_fbytes [DEPTH];
   logic [31:0]  flow_rpkts  [DEPTH];
   logic [47:0]  flow_rbytes [DEPTH];
   logic [31:0]  flow_ssecs  [DEPTH];
   logic [19:0]  flow_susecs [DEPTH];
   logic [31:0]  next_tcp_stream = '0;
   logic [31:0]  next_udp_stream = '0;

   packet_type      pending_packets[$];
   flow_report_type expected_reports[$];
   packet_type      in_flight;
   int              gap_left;
   int              handed_count, error_count;
   int              n_created, n_updated, n_full, n_reverse, n_ignored;

   function automatic logic [31:0] bump_pkts(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [47:0] add_bytes(logic [47:0] v, logic [15:0] len);
      logic [48:0] sum;
      sum = {1'b0, v} + len;
      return sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
   endfunction

   // Looks the packet up in the mirrored table and updates it as the block should.
   task automatic track_flow(input packet_type p, output bit answers,
                             output flow_report_type r);
      int           hit, free_slot;
      bit           rev;
      flow_key_type swapped;
      hit = -1; free_slot = -1; rev = 1'b0;
      r = '{default: '0};
      answers = (p.key.proto == PROTO_TCP) || (p.key.proto == PROTO_UDP);
      if (!answers) return;
      swapped = '{src: p.key.dst, dst: p.key.src, proto: p.key.proto,
                  sport: p.key.dport, dport: p.key.sport};
      // stored orientation wins over reversed, so scan it first
      for (int i = 0; i < DEPTH && hit < 0; i++)
         if (flow_used[i] && flow_key[i] == p.key) hit = i;
      for (int i = 0; i < DEPTH && hit < 0; i++)
         if (flow_used[i] && flow_key[i] == swapped) begin
            hit = i;
            rev = 1'b1;
         end
      if (hit >= 0) begin
         flow_tpkts[hit]  = bump_pkts(flow_tpkts[hit]);
         flow_tbytes[hit] = add_bytes(flow_tbytes[hit], p.length);
         if (rev) begin
            flow_rpkts[hit]  = bump_pkts(flow_rpkts[hit]);
            flow_rbytes[hit] = add_bytes(flow_rbytes[hit], p.length);
         end else begin
            flow_fpkts[hit]  = bump_pkts(flow_fpkts[hit]);
            flow_fbytes[hit] = add_bytes(flow_fbytes[hit], p.length);
         end
         r.status = STATUS_UPDATED;
         r.direction = rev;
      end else begin
         for (int i = 0; i < DEPTH && free_slot < 0; i++)
            if (!flow_used[i]) free_slot = i;
         if (free_slot < 0) begin
            r.status = STATUS_FULL;
            return;
         end
         hit = free_slot;
         flow_used[hit] = 1'b1;
         flow_key[hit]  = p.key;
         if (p.key.proto == PROTO_UDP) begin
            flow_stream[hit] = next_udp_stream;
            next_udp_stream++;
         end else begin
            flow_stream[hit] = next_tcp_stream;
            next_tcp_stream++;
         end
         flow_tpkts[hit]  = 32'd1;
         flow_tbytes[hit] = 48'(p.length);
         flow_fpkts[hit]  = 32'd1;
         flow_fbytes[hit] = 48'(p.length);
         flow_rpkts[hit]  = '0;
         flow_rbytes[hit] = '0;
         flow_ssecs[hit]  = p.secs;
         flow_susecs[hit] = p.usecs;
         r.status = STATUS_CREATED;
      end
      r.stream      = flow_stream[hit];
      r.tot_pkts    = flow_tpkts[hit];
      r.tot_bytes   = flow_tbytes[hit];
      r.fwd_pkts    = flow_fpkts[hit];
      r.fwd_bytes   = flow_fbytes[hit];
      r.rev_pkts    = flow_rpkts[hit];
      r.rev_bytes   = flow_rbytes[hit];
      r.start_secs  = flow_ssecs[hit];
      r.start_usecs = flow_susecs[hit];
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   task automatic check_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   // ---- driver: items handed over when start is high and busy low ----
   always @(posedge clock) begin
      bit              answers;
      flow_report_type rep;
      bit              handed;
      if (reset) begin
         start <= 1'b0;
      end else begin
         handed = start && !busy;
         if (handed) begin
            track_flow(in_flight, answers, rep);
            handed_count++;
            if (answers) begin
               expected_reports = {expected_reports, rep};
               if (rep.status == STATUS_CREATED) n_created++;
               else if (rep.status == STATUS_FULL) n_full++;
               else n_updated++;
               if (rep.direction) n_reverse++;
            end else begin
               n_ignored++;
            end
            // idling in bursts; some phases and the tail run flat out
            if (pending_packets.size() > QUIET_TAIL && (handed_count / 200) % 3 != 2
                && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 11);
         end
         if (start && !handed) begin
            // hold the item until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_packets.size() > 0 &&
                      !(pending_packets[0].drain_first && expected_reports.size() > 0)) begin
            in_flight = pending_packets.pop_front();
            req_src_address   <= in_flight.key.src;
            req_dst_address   <= in_flight.key.dst;
            req_ip_protocol   <= in_flight.key.proto;
            req_src_port      <= in_flight.key.sport;
            req_dst_port      <= in_flight.key.dport;
            req_packet_length <= in_flight.length;
            req_ts_seconds    <= in_flight.secs;
            req_ts_micros     <= in_flight.usecs;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---- monitor: a response lasts one cycle and cannot be held off ----
   always @(posedge clock) begin
      flow_report_type want;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected response status", rsp_status, '0);
         end else begin
            want = expected_reports.pop_front();
            check_field("status",        rsp_status,        want.status);
            check_field("direction",     rsp_direction,     want.direction);
            check_field("stream_number", rsp_stream_number, want.stream);
            check_field("total_packets", rsp_total_packets, want.tot_pkts);
            check_field("total_bytes",   rsp_total_bytes,   want.tot_bytes);
            check_field("fwd_packets",   rsp_fwd_packets,   want.fwd_pkts);
            check_field("fwd_bytes",     rsp_fwd_bytes,     want.fwd_bytes);
            check_field("rev_packets",   rsp_rev_packets,   want.rev_pkts);
            check_field("rev_bytes",     rsp_rev_bytes,     want.rev_bytes);
            check_field("start_seconds", rsp_start_seconds, want.start_secs);
            check_field("start_micros",  rsp_start_micros,  want.start_usecs);
         end
      end
   end

   function automatic packet_type make_packet(flow_key_type k, logic [15:0] len,
                                              logic [31:0] s, logic [19:0] us);
      packet_type p;
      p.key = k; p.length = len; p.secs = s; p.usecs = us; p.drain_first = 1'b0;
      return p;
   endfunction

   function automatic flow_key_type reversed(flow_key_type k);
      return '{src: k.dst, dst: k.src, proto: k.proto, sport: k.dport, dport: k.sport};
   endfunction

   function automatic logic [15:0] rand_length();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [19:0] rand_usecs();
      // now and then beyond a second, stored as given
      return ($urandom_range(0, 9) == 0) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                         : 20'($urandom_range(0, 999999));
   endfunction

   // ---- stimulus ----
   initial begin
      flow_key_type pool[$];
      flow_key_type k, k0, k1, self_key;
      packet_type   p;
      int           pick;
      logic [7:0]   other;

      // directed: field extremes, both orientations, both protocols, ignored ones
      k0 = '{src: '0, dst: '0, proto: PROTO_TCP, sport: '0, dport: '0};   // also self-matching
      k1 = '{src: '1, dst: 32'h0A00_0001, proto: PROTO_UDP, sport: '1, dport: 16'd53};
      self_key = '{src: 32'hC0A8_0101, dst: 32'hC0A8_0101, proto: PROTO_UDP,
                   sport: 16'd5000, dport: 16'd5000};
      pending_packets = {pending_packets, make_packet(k0, 16'd0, 32'd0, 20'd0)};
      pending_packets = {pending_packets, make_packet(k0, 16'hFFFF, '1, 20'hFFFFF)};
      pending_packets = {pending_packets, make_packet(k1, 16'hFFFF, '1, 20'd999999)};
      pending_packets = {pending_packets,
                         make_packet(reversed(k1), 16'd1500, 32'd7, 20'd1)};
      pending_packets = {pending_packets,
                         make_packet(reversed(k1), 16'hFFFF, 32'd8, 20'hFFFFF)};
      pending_packets = {pending_packets, make_packet(k1, 16'd64, 32'd9, 20'd2)};
      k = k1; k.proto = PROTO_TCP;   // same tuple, other protocol: separate flow
      pending_packets = {pending_packets,
                         make_packet(k, 16'd40, 32'h8000_0000, 20'd1000000)};
      pending_packets = {pending_packets, make_packet(self_key, 16'd100, 32'd1, 20'd5)};
      pending_packets = {pending_packets, make_packet(self_key, 16'd200, 32'd2, 20'd6)};
      p = make_packet(reversed(k), 16'd60, 32'd3, 20'd3);
      p.drain_first = 1'b1;
      pending_packets = {pending_packets, p};
      for (int j = 0; j < 3; j++) begin
         k = k1;
         k.proto = (j == 0) ? 8'd0 : (j == 1) ? 8'hFF : 8'd1;
         pending_packets = {pending_packets, make_packet(k, '1, '1, '1)};
      end
      pool = {pool, k0};
      pool = {pool, k1};
      pool = {pool, self_key};

      // random: mostly traffic on known flows, new flows enough to fill the table, other protocols
      for (int n = 0; n < NUM_RANDOM; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            k.src = $urandom; k.dst = $urandom;
            k.sport = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023))
                                                  : 16'($urandom_range(0, 65535));
            k.dport = 16'($urandom_range(0, 65535));
            k.proto = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
            pool = {pool, k};
         end else if (pick < 20) begin
            k.src = $urandom; k.dst = $urandom;
            k.sport = 16'($urandom_range(0, 65535));
            k.dport = 16'($urandom_range(0, 65535));
            do other = 8'($urandom_range(0, 255));
            while (other == PROTO_TCP || other == PROTO_UDP);
            k.proto = other;
         end else begin
            k = pool[$urandom_range(0, pool.size() - 1)];
            if ($urandom_range(0, 1)) k = reversed(k);
         end
         p = make_packet(k, rand_length(), $urandom, rand_usecs());
         p.drain_first = ($urandom_range(0, 399) == 0);
         pending_packets = {pending_packets, p};
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_packets.size() > 0 || start || expected_reports.size() > 0);
      repeat (SETTLE) @(posedge clock);

      $display("Items handed over: %0d (%0d ignored protocols)", handed_count, n_ignored);
      $display("Flows created %0d, updated %0d (%0d reversed), table full %0d",
               n_created, n_updated, n_reverse, n_full);
      if (error_count == 0 && expected_reports.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d responses outstanding", expected_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
